// ----- rtl/rwmc_pkg.sv -----
// Package for the random-walk maze carver: codes, cell bit layout,
// size clamping and the boundary wall pattern.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rwmc_pkg;

  localparam int MAX_COLS_DEF = 64;
  localparam int MAX_ROWS_DEF = 64;

  localparam int CNT_W    = 14;  // up to 127*127 cells
  localparam int SIZE_W   = 7;
  localparam int COORD_W  = 9;   // scratch width for coordinates and sizes
  localparam int CELL_W   = 5;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

  // Cell bits
  localparam logic [CELL_W-1:0] WALL_LEFT   = 5'h01;
  localparam logic [CELL_W-1:0] WALL_TOP    = 5'h02;
  localparam logic [CELL_W-1:0] WALL_RIGHT  = 5'h04;
  localparam logic [CELL_W-1:0] WALL_BOTTOM = 5'h08;
  localparam logic [CELL_W-1:0] CELL_VISIT  = 5'h10;
  localparam int VISIT_BIT = 4;

  // Function codes
  localparam logic [1:0] FUNC_START = 2'd0;
  localparam logic [1:0] FUNC_MOVE  = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  // Directions
  localparam logic [1:0] DIR_LEFT  = 2'd0;
  localparam logic [1:0] DIR_RIGHT = 2'd1;
  localparam logic [1:0] DIR_UP    = 2'd2;
  localparam logic [1:0] DIR_DOWN  = 2'd3;

  // Result status
  localparam logic [2:0] STAT_CARVED   = 3'd0;
  localparam logic [2:0] STAT_VISITED  = 3'd1;
  localparam logic [2:0] STAT_OFFGRID  = 3'd2;
  localparam logic [2:0] STAT_BADCOORD = 3'd3;
  localparam logic [2:0] STAT_READ     = 3'd4;

  // Register indexes (address bit 2)
  localparam logic REG_COLS = 1'b0;
  localparam logic REG_ROWS = 1'b1;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_MARK,
    ST_MV_EVAL,
    ST_MV_DST,
    ST_RD
  } state_t;

  // Clamp a raw size register to 2..maxv.
  function automatic logic [SIZE_W-1:0] eff_size(logic [SIZE_W-1:0] raw, int maxv);
    logic [SIZE_W-1:0] res;
    res = raw;
    if (raw < 7'd2) begin
      res = 7'd2;
    end else if (int'(raw) > maxv) begin
      res = SIZE_W'(maxv);
    end
    return res;
  endfunction

  // Boundary wall pattern of one cell for a grid of nc by nr cells.
  function automatic logic [CELL_W-1:0] cell_init(logic [COORD_W-1:0] c,
                                                  logic [COORD_W-1:0] r,
                                                  logic [SIZE_W-1:0] nc,
                                                  logic [SIZE_W-1:0] nr);
    logic [CELL_W-1:0]  v;
    logic [COORD_W-1:0] last_c;
    logic [COORD_W-1:0] last_r;
    last_c = {2'b00, nc} - 9'd1;
    last_r = {2'b00, nr} - 9'd1;
    v = WALL_LEFT | WALL_TOP;
    if (c == '0 && r == '0) begin
      v = WALL_TOP;
    end
    if (r == last_r) begin
      v = v | WALL_BOTTOM;
    end
    if (c == last_c && r < last_r) begin
      v = v | WALL_RIGHT;
    end
    return v;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/random_walk_maze_carver_top.sv -----
// Random-walk (Aldous-Broder) maze carver: cell memory, walker and sequencer.
// Depends on rwmc_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   Input beat: start high while busy is low. in_func picks the job:
//   start a maze at (in_cell_col, in_cell_row), move the walker one cell in
//   in_direction, or read one cell's walls and visited mark.
//   Every beat gives exactly one result beat: out_strobe is high for one
//   cycle with the payload; the receiver cannot stall and must take it.
//   Flow per job (the cell memory's single write port shapes it):
//     rejected item (bad coordinates, off-grid move, unused code): result
//       in the cycle after the beat, next beat taken at once.
//     read: ST_RD.  move: ST_MV_EVAL, plus ST_MV_DST when a left or up
//       move carves, since both the old and the new cell are written back.
//     start: ST_CLEAR, then ST_MARK: the whole memory is rewritten with
//       the boundary wall pattern, one entry a cycle.
//   Reset: the same rewrite runs once after reset with busy high; register
//   writes are taken.  Sizes are to be written over the APB port only while
//   the block is idle; the block itself does not enforce this.
module random_walk_maze_carver_top #(
  parameter int MAX_COLS = rwmc_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = rwmc_pkg::MAX_ROWS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // command channel
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_func,
  input  wire logic [1:0]  in_direction,
  input  wire logic [5:0]  in_cell_col,
  input  wire logic [5:0]  in_cell_row,
  // result channel
  output logic             out_strobe,
  output logic [2:0]       out_status,
  output logic [5:0]       out_walker_col,
  output logic [5:0]       out_walker_row,
  output logic [12:0]      out_remaining,
  output logic             out_done_res,
  output logic [3:0]       out_walls,
  output logic             out_visited,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int CW    = $clog2(MAX_COLS);
  localparam int RW    = $clog2(MAX_ROWS);
  localparam int AW    = CW + RW;
  localparam int DEPTH = 1 << AW;
  localparam int CNTW  = rwmc_pkg::CNT_W;
  localparam int SW    = rwmc_pkg::SIZE_W;
  localparam int XW    = rwmc_pkg::COORD_W;
  localparam int VW    = rwmc_pkg::CELL_W;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [SW-1:0] cols_r;
  logic [SW-1:0] rows_r;
  logic          cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= rwmc_pkg::SIZE_RESET;
      rows_r <= rwmc_pkg::SIZE_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        rwmc_pkg::REG_COLS: cols_r <= pwdata[SW-1:0];
        rwmc_pkg::REG_ROWS: rows_r <= pwdata[SW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      rwmc_pkg::REG_COLS: prdata = {{(32-SW){1'b0}}, cols_r};
      rwmc_pkg::REG_ROWS: prdata = {{(32-SW){1'b0}}, rows_r};
      default:            prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------
  rwmc_pkg::state_t state_r, state_nxt;

  logic [SW-1:0]   nc, nr;                 // clamped live sizes
  logic [SW-1:0]   fill_nc_r, fill_nc_nxt; // sizes of the pattern being built
  logic [SW-1:0]   fill_nr_r, fill_nr_nxt;
  logic [AW-1:0]   pass_r, pass_nxt;
  logic [CW-1:0]   walker_x_r, walker_x_nxt;
  logic [RW-1:0]   walker_y_r, walker_y_nxt;
  logic [CW-1:0]   tgt_x_r, tgt_x_nxt;
  logic [RW-1:0]   tgt_y_r, tgt_y_nxt;
  logic [1:0]      dir_r, dir_nxt;
  logic [VW-1:0]   cache_r, cache_nxt;     // copy of the walker's cell
  logic [VW-1:0]   dst_val_r, dst_val_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;

  logic [SW-1:0]   fill_nc_rst, fill_nr_rst;
  logic [VW-1:0]   cache_rst;

  // Cell memory: one write and one registered read per cycle.
  logic [VW-1:0]   mem [DEPTH];
  logic [VW-1:0]   mem_rdata_r;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [VW-1:0]   mem_wdata;
  logic [AW-1:0]   mem_raddr;

  // Result
  logic            res_v;
  logic [2:0]      res_status;
  logic [3:0]      res_walls;
  logic            res_vis;
  logic            out_strobe_r;
  logic [2:0]      out_status_r;
  logic [5:0]      out_walker_col_r;
  logic [5:0]      out_walker_row_r;
  logic [12:0]     out_remaining_r;
  logic            out_done_res_r;
  logic [3:0]      out_walls_r;
  logic            out_visited_r;

  // ---------------------------------------------------------------------
  // Command decode
  // ---------------------------------------------------------------------
  logic          accept;
  logic [XW-1:0] col9, row9, wx9, wy9, tx9, ty9, nc9, nr9;
  logic          in_grid;
  logic          off_grid;
  logic [XW-1:0] wxn9, wyn9;
  logic [VW-1:0] new_dst;
  logic [VW-1:0] mark_val;
  logic [CNTW-1:0] cells_prod;

  assign nc = rwmc_pkg::eff_size(cols_r, MAX_COLS);
  assign nr = rwmc_pkg::eff_size(rows_r, MAX_ROWS);
  assign fill_nc_rst = rwmc_pkg::eff_size(rwmc_pkg::SIZE_RESET, MAX_COLS);
  assign fill_nr_rst = rwmc_pkg::eff_size(rwmc_pkg::SIZE_RESET, MAX_ROWS);
  assign cache_rst   = rwmc_pkg::cell_init('0, '0, fill_nc_rst, fill_nr_rst);

  assign busy   = (state_r != rwmc_pkg::ST_IDLE);
  assign accept = start && !busy;

  assign col9 = XW'(in_cell_col);
  assign row9 = XW'(in_cell_row);
  assign wx9  = XW'(walker_x_r);
  assign wy9  = XW'(walker_y_r);
  assign nc9  = XW'(nc);
  assign nr9  = XW'(nr);
  assign in_grid = (col9 < nc9) && (row9 < nr9);

  // Neighbor cell; a step below zero wraps but is flagged off-grid.
  always_comb begin
    tx9 = wx9;
    ty9 = wy9;
    off_grid = 1'b0;
    case (in_direction)
      rwmc_pkg::DIR_LEFT: begin
        tx9 = wx9 - 9'd1;
        off_grid = (wx9 == '0);
      end
      rwmc_pkg::DIR_RIGHT: tx9 = wx9 + 9'd1;
      rwmc_pkg::DIR_UP: begin
        ty9 = wy9 - 9'd1;
        off_grid = (wy9 == '0);
      end
      rwmc_pkg::DIR_DOWN: ty9 = wy9 + 9'd1;
      default: ;
    endcase
    off_grid = off_grid || (tx9 >= nc9) || (ty9 >= nr9);
  end

  // Read port: neighbor for a move, addressed cell otherwise.
  assign mem_raddr = (in_func == rwmc_pkg::FUNC_MOVE) ?
                     {tx9[CW-1:0], ty9[RW-1:0]} : {col9[CW-1:0], row9[RW-1:0]};

  // Entered cell after carving: mark it, drop the wall it shares with the
  // old cell when that wall is stored in the new cell.
  always_comb begin
    new_dst = mem_rdata_r | rwmc_pkg::CELL_VISIT;
    case (dir_r)
      rwmc_pkg::DIR_RIGHT: new_dst = new_dst & ~rwmc_pkg::WALL_LEFT;
      rwmc_pkg::DIR_DOWN:  new_dst = new_dst & ~rwmc_pkg::WALL_TOP;
      default: ;
    endcase
  end

  assign mark_val = rwmc_pkg::cell_init(XW'(tgt_x_r), XW'(tgt_y_r), fill_nc_r, fill_nr_r)
                    | rwmc_pkg::CELL_VISIT;
  assign cells_prod = CNTW'(fill_nc_r) * CNTW'(fill_nr_r);

  // ---------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rwmc_pkg::ST_INIT: begin
        if (pass_r == '1) state_nxt = rwmc_pkg::ST_IDLE;
      end
      rwmc_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_func)
            rwmc_pkg::FUNC_START: if (in_grid) state_nxt = rwmc_pkg::ST_CLEAR;
            rwmc_pkg::FUNC_MOVE:  if (!off_grid) state_nxt = rwmc_pkg::ST_MV_EVAL;
            rwmc_pkg::FUNC_READ:  if (in_grid) state_nxt = rwmc_pkg::ST_RD;
            default: ;
          endcase
        end
      end
      rwmc_pkg::ST_CLEAR: begin
        if (pass_r == '1) state_nxt = rwmc_pkg::ST_MARK;
      end
      rwmc_pkg::ST_MARK: state_nxt = rwmc_pkg::ST_IDLE;
      rwmc_pkg::ST_MV_EVAL: begin
        if (!mem_rdata_r[rwmc_pkg::VISIT_BIT] &&
            (dir_r == rwmc_pkg::DIR_LEFT || dir_r == rwmc_pkg::DIR_UP)) begin
          state_nxt = rwmc_pkg::ST_MV_DST;
        end else begin
          state_nxt = rwmc_pkg::ST_IDLE;
        end
      end
      rwmc_pkg::ST_MV_DST: state_nxt = rwmc_pkg::ST_IDLE;
      rwmc_pkg::ST_RD:     state_nxt = rwmc_pkg::ST_IDLE;
      default:             state_nxt = rwmc_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------
  // Datapath, memory writes and results
  // ---------------------------------------------------------------------
  always_comb begin
    fill_nc_nxt  = fill_nc_r;
    fill_nr_nxt  = fill_nr_r;
    pass_nxt     = pass_r;
    walker_x_nxt = walker_x_r;
    walker_y_nxt = walker_y_r;
    tgt_x_nxt    = tgt_x_r;
    tgt_y_nxt    = tgt_y_r;
    dir_nxt      = dir_r;
    cache_nxt    = cache_r;
    dst_val_nxt  = dst_val_r;
    cnt_nxt      = cnt_r;
    mem_we       = 1'b0;
    mem_waddr    = pass_r;
    mem_wdata    = rwmc_pkg::cell_init(XW'(pass_r[AW-1:RW]), XW'(pass_r[RW-1:0]),
                                       fill_nc_r, fill_nr_r);
    res_v        = 1'b0;
    res_status   = rwmc_pkg::STAT_BADCOORD;
    res_walls    = '0;
    res_vis      = 1'b0;

    case (state_r)
      rwmc_pkg::ST_INIT, rwmc_pkg::ST_CLEAR: begin
        // sweep the boundary pattern over every entry
        mem_we   = 1'b1;
        pass_nxt = pass_r + AW'(1);
      end
      rwmc_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_func)
            rwmc_pkg::FUNC_START: begin
              if (in_grid) begin
                tgt_x_nxt   = col9[CW-1:0];
                tgt_y_nxt   = row9[RW-1:0];
                fill_nc_nxt = nc;
                fill_nr_nxt = nr;
                pass_nxt    = '0;
              end else begin
                res_v = 1'b1;
              end
            end
            rwmc_pkg::FUNC_MOVE: begin
              if (off_grid) begin
                res_v      = 1'b1;
                res_status = rwmc_pkg::STAT_OFFGRID;
              end else begin
                tgt_x_nxt = tx9[CW-1:0];
                tgt_y_nxt = ty9[RW-1:0];
                dir_nxt   = in_direction;
              end
            end
            rwmc_pkg::FUNC_READ: begin
              if (!in_grid) res_v = 1'b1;
            end
            default: res_v = 1'b1;
          endcase
        end
      end
      rwmc_pkg::ST_MARK: begin
        mem_we       = 1'b1;
        mem_waddr    = {tgt_x_r, tgt_y_r};
        mem_wdata    = mark_val;
        cache_nxt    = mark_val;
        walker_x_nxt = tgt_x_r;
        walker_y_nxt = tgt_y_r;
        cnt_nxt      = cells_prod - CNTW'(1);
        res_v        = 1'b1;
        res_status   = rwmc_pkg::STAT_CARVED;
      end
      rwmc_pkg::ST_MV_EVAL: begin
        walker_x_nxt = tgt_x_r;
        walker_y_nxt = tgt_y_r;
        res_v        = 1'b1;
        if (!mem_rdata_r[rwmc_pkg::VISIT_BIT]) begin
          res_status = rwmc_pkg::STAT_CARVED;
          cache_nxt  = new_dst;
          if (cnt_r != '0) cnt_nxt = cnt_r - CNTW'(1);
          mem_we = 1'b1;
          if (dir_r == rwmc_pkg::DIR_LEFT || dir_r == rwmc_pkg::DIR_UP) begin
            // drop the shared wall in the old cell now, write the new one next
            mem_waddr   = {walker_x_r, walker_y_r};
            mem_wdata   = cache_r & ~((dir_r == rwmc_pkg::DIR_LEFT) ?
                                      rwmc_pkg::WALL_LEFT : rwmc_pkg::WALL_TOP);
            dst_val_nxt = new_dst;
          end else begin
            mem_waddr = {tgt_x_r, tgt_y_r};
            mem_wdata = new_dst;
          end
        end else begin
          res_status = rwmc_pkg::STAT_VISITED;
          cache_nxt  = mem_rdata_r;
        end
      end
      rwmc_pkg::ST_MV_DST: begin
        mem_we    = 1'b1;
        mem_waddr = {walker_x_r, walker_y_r};
        mem_wdata = dst_val_r;
      end
      rwmc_pkg::ST_RD: begin
        res_v      = 1'b1;
        res_status = rwmc_pkg::STAT_READ;
        res_walls  = mem_rdata_r[3:0];
        res_vis    = mem_rdata_r[rwmc_pkg::VISIT_BIT];
      end
      default: ;
    endcase
  end

  assign wxn9 = XW'(walker_x_nxt);
  assign wyn9 = XW'(walker_y_nxt);

  // ---------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= rwmc_pkg::ST_INIT;
      pass_r       <= '0;
      fill_nc_r    <= fill_nc_rst;
      fill_nr_r    <= fill_nr_rst;
      walker_x_r   <= '0;
      walker_y_r   <= '0;
      cache_r      <= cache_rst;
      cnt_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pass_r       <= pass_nxt;
      fill_nc_r    <= fill_nc_nxt;
      fill_nr_r    <= fill_nr_nxt;
      walker_x_r   <= walker_x_nxt;
      walker_y_r   <= walker_y_nxt;
      cache_r      <= cache_nxt;
      cnt_r        <= cnt_nxt;
      out_strobe_r <= res_v;
    end
  end

  always_ff @(posedge clk) begin
    tgt_x_r   <= tgt_x_nxt;
    tgt_y_r   <= tgt_y_nxt;
    dir_r     <= dir_nxt;
    dst_val_r <= dst_val_nxt;
    if (res_v) begin
      out_status_r     <= res_status;
      out_walker_col_r <= wxn9[5:0];
      out_walker_row_r <= wyn9[5:0];
      out_remaining_r  <= cnt_nxt[12:0];
      out_done_res_r   <= (cnt_nxt == '0);
      out_walls_r      <= res_walls;
      out_visited_r    <= res_vis;
    end
  end

  // Cell memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_r <= mem[mem_raddr];
  end

  assign out_strobe     = out_strobe_r;
  assign out_status     = out_status_r;
  assign out_walker_col = out_walker_col_r;
  assign out_walker_row = out_walker_row_r;
  assign out_remaining  = out_remaining_r;
  assign out_done_res   = out_done_res_r;
  assign out_walls      = out_walls_r;
  assign out_visited    = out_visited_r;

endmodule

`default_nettype wire

// ----- verif/random_walk_maze_carver_top_tb.sv -----
// Testbench for the random-walk maze carver: a scoreboard class tracks the maze,
// walker and unvisited count and checks every result beat; plain tasks drive it.
// Depends on rwmc_pkg and random_walk_maze_carver_top.
`timescale 1ns / 1ps

import rwmc_pkg::*;

typedef struct packed {
  logic [2:0]  status;
  logic [5:0]  walker_col;
  logic [5:0]  walker_row;
  logic [12:0] remaining;
  logic        done_res;
  logic [3:0]  walls;
  logic        visited;
} maze_result_t;

class maze_ledger;
  logic [CELL_W-1:0] cells [MAX_COLS_DEF*MAX_ROWS_DEF];
  int                cols_raw;
  int                rows_raw;
  int                walk_col;
  int                walk_row;
  int                unvisited;
  maze_result_t      awaited [$];
  int                mismatches;
  int                checked;
  int                tally [5];
  int                completed;

  function new();
    cols_raw  = 64;
    rows_raw  = 64;
    walk_col  = 0;
    walk_row  = 0;
    unvisited = 0;
    lay_out(64, 64);
  endfunction

  function int span(int raw, int maxv);
    if (raw < 2) return 2;
    if (raw > maxv) return maxv;
    return raw;
  endfunction

  function int eff_cols();
    return span(cols_raw, MAX_COLS_DEF);
  endfunction

  function int eff_rows();
    return span(rows_raw, MAX_ROWS_DEF);
  endfunction

  function int slot(int c, int r);
    return c * MAX_ROWS_DEF + r;
  endfunction

  // Boundary pattern over the whole store: left and top walls everywhere,
  // open entrance at the origin, bottom row closed, right column closed but
  // for its bottom cell.
  function void lay_out(int nc, int nr);
    logic [CELL_W-1:0] v;
    for (int c = 0; c < MAX_COLS_DEF; c++) begin
      for (int r = 0; r < MAX_ROWS_DEF; r++) begin
        v = (c == 0 && r == 0) ? WALL_TOP : (WALL_LEFT | WALL_TOP);
        if (r == nr - 1) v = v | WALL_BOTTOM;
        if (c == nc - 1 && r < nr - 1) v = v | WALL_RIGHT;
        cells[slot(c, r)] = v;
      end
    end
  endfunction

  function void set_size(logic reg_sel, logic [6:0] value);
    if (reg_sel == REG_COLS) cols_raw = value;
    else rows_raw = value;
  endfunction

  function void note_command(logic [1:0] fn, logic [1:0] dir, logic [5:0] col,
                             logic [5:0] row);
    maze_result_t res;
    int nc, nr, tx, ty, src, dst;
    bit in_grid;
    nc = eff_cols();
    nr = eff_rows();
    res = '0;
    res.status = STAT_BADCOORD;
    in_grid = (int'(col) < nc) && (int'(row) < nr);
    if (fn == FUNC_START) begin
      if (in_grid) begin
        lay_out(nc, nr);
        cells[slot(col, row)] = cells[slot(col, row)] | CELL_VISIT;
        unvisited = nc * nr - 1;
        walk_col = col;
        walk_row = row;
        res.status = STAT_CARVED;
      end
    end else if (fn == FUNC_MOVE) begin
      tx = walk_col + ((dir == DIR_LEFT) ? -1 : (dir == DIR_RIGHT) ? 1 : 0);
      ty = walk_row + ((dir == DIR_UP) ? -1 : (dir == DIR_DOWN) ? 1 : 0);
      if (tx < 0 || ty < 0 || tx >= nc || ty >= nr) begin
        res.status = STAT_OFFGRID;
      end else begin
        src = slot(walk_col, walk_row);
        dst = slot(tx, ty);
        if (!cells[dst][VISIT_BIT]) begin
          cells[dst] = cells[dst] | CELL_VISIT;
          // count saturates at zero when no start set it up
          if (unvisited > 0) begin
            unvisited--;
            if (unvisited == 0) completed++;
          end
          if (dir == DIR_LEFT) cells[src] = cells[src] & ~WALL_LEFT;
          else if (dir == DIR_RIGHT) cells[dst] = cells[dst] & ~WALL_LEFT;
          else if (dir == DIR_UP) cells[src] = cells[src] & ~WALL_TOP;
          else cells[dst] = cells[dst] & ~WALL_TOP;
          res.status = STAT_CARVED;
        end else begin
          res.status = STAT_VISITED;
        end
        walk_col = tx;
        walk_row = ty;
      end
    end else if (fn == FUNC_READ) begin
      if (in_grid) begin
        res.walls   = cells[slot(col, row)][3:0];
        res.visited = cells[slot(col, row)][VISIT_BIT];
        res.status  = STAT_READ;
      end
    end
    res.walker_col = walk_col[5:0];
    res.walker_row = walk_row[5:0];
    res.remaining  = unvisited[12:0];
    res.done_res   = (unvisited == 0);
    tally[res.status]++;
    awaited.push_back(res);
  endfunction

  function void check_result(maze_result_t got);
    maze_result_t want;
    if (awaited.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("%0t: result beat with nothing awaited: %p", $time, got);
      return;
    end
    want = awaited.pop_front();
    checked++;
    if (got.status !== want.status || got.walker_col !== want.walker_col ||
        got.walker_row !== want.walker_row || got.remaining !== want.remaining ||
        got.done_res !== want.done_res || got.walls !== want.walls ||
        got.visited !== want.visited) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: result %0d differs", $time, checked);
        $display("  expected status %0d walker (%0d,%0d) remaining %0d done %0b walls %h vis %0b",
                 want.status, want.walker_col, want.walker_row, want.remaining,
                 want.done_res, want.walls, want.visited);
        $display("  actual   status %0d walker (%0d,%0d) remaining %0d done %0b walls %h vis %0b",
                 got.status, got.walker_col, got.walker_row, got.remaining,
                 got.done_res, got.walls, got.visited);
      end
    end
  endfunction
endclass

module random_walk_maze_carver_top_tb;

  // Unused function code; the block must reject it like bad coordinates.
  localparam logic [1:0] FUNC_SPARE = 2'd3;
  localparam int N_PHASES   = 10;
  localparam int PHASE_LEN  = 88;
  // A start rewrites all 4096 entries; allow several of those with no beat.
  localparam int IDLE_LIMIT = 25000;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_func;
  logic [1:0]  in_direction;
  logic [5:0]  in_cell_col;
  logic [5:0]  in_cell_row;
  logic        out_strobe;
  logic [2:0]  out_status;
  logic [5:0]  out_walker_col;
  logic [5:0]  out_walker_row;
  logic [12:0] out_remaining;
  logic        out_done_res;
  logic [3:0]  out_walls;
  logic        out_visited;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  maze_ledger ledger = new();
  int         commands_sent;

  random_walk_maze_carver_top i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_func        (in_func),
    .in_direction   (in_direction),
    .in_cell_col    (in_cell_col),
    .in_cell_row    (in_cell_row),
    .out_strobe     (out_strobe),
    .out_status     (out_status),
    .out_walker_col (out_walker_col),
    .out_walker_row (out_walker_row),
    .out_remaining  (out_remaining),
    .out_done_res   (out_done_res),
    .out_walls      (out_walls),
    .out_visited    (out_visited),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Take every result beat at the edge that ends its cycle; the block
  // cannot be held off, so there is nothing to stall here.
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      ledger.check_result('{out_status, out_walker_col, out_walker_row, out_remaining,
                            out_done_res, out_walls, out_visited});
    end
  end

  // Watchdog: end the run when no beat moves on either side for too long.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || out_strobe) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

  // Present one command at the falling edge and hold it until the block takes
  // it. Leave start high on return so back-to-back beats need no toggle.
  task automatic issue(input logic [1:0] fn, input logic [1:0] dir,
                       input logic [5:0] col, input logic [5:0] row);
    in_func      = fn;
    in_direction = dir;
    in_cell_col  = col;
    in_cell_row  = row;
    start        = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    ledger.note_command(fn, dir, col, row);
    commands_sent++;
    @(negedge clk);
  endtask

  // Drop start and wait until every awaited result is in and the block idles.
  task automatic settle();
    start = 1'b0;
    while (ledger.awaited.size() != 0 || busy) @(negedge clk);
  endtask

  // APB write: setup cycle, then access cycle completed when pready is high.
  task automatic write_size(input logic reg_sel, input logic [6:0] value);
    paddr   = {reg_sel, 2'b00};
    pwdata  = {25'd0, value};
    pwrite  = 1'b1;
    psel    = 1'b1;
    penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    ledger.set_size(reg_sel, value);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  initial begin : stimulus
    int col_set [N_PHASES] = '{64, 0, 127, 5, 2, 64, 127, -1, -1, 4};
    int row_set [N_PHASES] = '{64, 1, 127, 3, 64, 2, 0, -1, -1, 4};
    int nc, nr, pick, gap;
    logic [6:0] cval, rval;
    logic [1:0] fn, dir;
    logic [5:0] col, row;
    bit bursty;

    commands_sent = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_func = FUNC_START;
    in_direction = DIR_LEFT;
    in_cell_col = '0;
    in_cell_row = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    // hold off until the clearing pass after reset finishes
    settle();

    // Directed, reset sizes (64 x 64), no maze started yet: moves carve but
    // the count stays at zero.
    issue(FUNC_READ, DIR_LEFT, 6'd0, 6'd0);
    issue(FUNC_MOVE, DIR_RIGHT, 6'd0, 6'd0);
    issue(FUNC_MOVE, DIR_LEFT, 6'd0, 6'd0);
    issue(FUNC_MOVE, DIR_UP, 6'd0, 6'd0);
    issue(FUNC_SPARE, DIR_DOWN, 6'd63, 6'd63);
    issue(FUNC_READ, DIR_LEFT, 6'd63, 6'd63);
    issue(FUNC_READ, DIR_LEFT, 6'd63, 6'd62);
    // Start in the exit corner and walk off both far edges, then carve
    // up, left and down (each clears a different wall) and revisit.
    issue(FUNC_START, DIR_LEFT, 6'd63, 6'd63);
    issue(FUNC_MOVE, DIR_DOWN, 6'd0, 6'd0);
    issue(FUNC_MOVE, DIR_RIGHT, 6'd0, 6'd0);
    issue(FUNC_MOVE, DIR_UP, 6'd0, 6'd0);
    issue(FUNC_MOVE, DIR_LEFT, 6'd0, 6'd0);
    issue(FUNC_MOVE, DIR_DOWN, 6'd0, 6'd0);
    issue(FUNC_MOVE, DIR_RIGHT, 6'd0, 6'd0);
    issue(FUNC_READ, DIR_LEFT, 6'd63, 6'd62);
    issue(FUNC_READ, DIR_LEFT, 6'd62, 6'd63);
    issue(FUNC_READ, DIR_LEFT, 6'd62, 6'd62);

    // Directed, sizes below range (both act as 2): bad coordinates, then
    // walk the whole 2 x 2 maze to completion.
    settle();
    write_size(REG_COLS, 7'd0);
    write_size(REG_ROWS, 7'd1);
    issue(FUNC_START, DIR_LEFT, 6'd2, 6'd0);
    issue(FUNC_READ, DIR_LEFT, 6'd0, 6'd2);
    issue(FUNC_START, DIR_LEFT, 6'd1, 6'd1);
    issue(FUNC_MOVE, DIR_RIGHT, 6'd0, 6'd0);
    issue(FUNC_MOVE, DIR_UP, 6'd0, 6'd0);
    issue(FUNC_MOVE, DIR_LEFT, 6'd0, 6'd0);
    issue(FUNC_MOVE, DIR_DOWN, 6'd0, 6'd0);
    issue(FUNC_READ, DIR_LEFT, 6'd0, 6'd1);
    issue(FUNC_READ, DIR_LEFT, 6'd1, 6'd1);

    // Random phases: each picks a size setting (extremes and out-of-range
    // values among them), starts a maze and mostly walks it. The walker may
    // sit outside a shrunken grid when a phase begins.
    for (int p = 0; p < N_PHASES; p++) begin
      settle();
      cval = (col_set[p] < 0) ? 7'($urandom_range(0, 127)) : 7'(col_set[p]);
      rval = (row_set[p] < 0) ? 7'($urandom_range(0, 127)) : 7'(row_set[p]);
      write_size(REG_COLS, cval);
      write_size(REG_ROWS, rval);
      nc = ledger.eff_cols();
      nr = ledger.eff_rows();
      // no idling at all in the closing phases
      bursty = (p < N_PHASES - 2);
      if (p % 2 == 1) begin
        // leave the walker where the last phase put it for a few moves
        repeat (6) issue(FUNC_MOVE, 2'($urandom), 6'($urandom), 6'($urandom));
      end
      issue(FUNC_START, 2'($urandom), 6'($urandom_range(0, nc - 1)),
            6'($urandom_range(0, nr - 1)));
      for (int k = 0; k < PHASE_LEN; k++) begin
        pick = $urandom_range(0, 99);
        dir  = 2'($urandom);
        col  = 6'($urandom);
        row  = 6'($urandom);
        if (pick < 72) begin
          fn = FUNC_MOVE;
        end else if (pick < 88) begin
          fn  = FUNC_READ;
          col = 6'($urandom_range(0, nc - 1));
          row = 6'($urandom_range(0, nr - 1));
        end else if (pick < 90) begin
          fn  = FUNC_START;
          col = 6'($urandom_range(0, nc - 1));
          row = 6'($urandom_range(0, nr - 1));
        end else if (pick < 94) begin
          fn = FUNC_READ;
        end else if (pick < 96) begin
          fn = FUNC_START;
        end else begin
          fn = FUNC_SPARE;
        end
        issue(fn, dir, col, row);
        // Idle in bursts, with stretches of back-to-back commands in between.
        if (bursty && (k % 40) < 28 && $urandom_range(0, 3) == 0) begin
          gap = $urandom_range(1, 18);
          start = 1'b0;
          repeat (gap) @(negedge clk);
        end
        // Now and then hold the sender until everything is back.
        if (bursty && $urandom_range(0, 39) == 0) settle();
      end
    end

    settle();
    repeat (8) @(negedge clk);
    if (ledger.awaited.size() != 0) begin
      $display("%0d expected results never arrived", ledger.awaited.size());
    end
    $display("covered %0d commands over %0d size settings: %0d carved, %0d revisits, %0d off-grid",
             commands_sent, N_PHASES + 2, ledger.tally[STAT_CARVED],
             ledger.tally[STAT_VISITED], ledger.tally[STAT_OFFGRID]);
    $display("  %0d rejected, %0d reads, %0d mazes completed, %0d results checked",
             ledger.tally[STAT_BADCOORD], ledger.tally[STAT_READ], ledger.completed,
             ledger.checked);
    if (ledger.mismatches == 0 && ledger.awaited.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
